// ----- hdl/sorted_priority_queue_unit_assert.svh -----
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH_STEP,
    ST_PUSH_CMP,
    ST_POP_DATA
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;   // capture request fields
    logic    init_idx;  // scan index starts at the tail
    logic    rd_prev;   // read entry below the scan index
    logic    rd_head;   // read the head entry
    logic    shift;     // move read entry up one slot, step index down
    logic    insert;    // write new value at scan index, grow tail
    logic    pop_adv;   // advance head, drain if last entry
    logic    emit;      // load the result register
    status_t emit_status;
    logic    emit_pop;  // result carries the read entry
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic at_head;   // scan index reached the head
    logic rd_gt;     // read entry is greater than the new value
    logic out_free;  // result register can take a new result
  } spq_stat_t;

endpackage

// ----- hdl/sorted_priority_queue_unit.sv -----
// Sorted priority queue. Requests are worked on one at a time; a push scans down from
// the tail past every stored entry greater than the value, then inserts it. The next
// request is taken while a finished result still waits in the result register.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result.
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [spq_pkg::DATA_W-1:0] out_popped_value,
  output logic [spq_pkg::STATUS_W-1:0]      out_status
);
  import spq_pkg::*;

  // Controller sequences each request:
  //   IDLE      take request
  //   EXEC      full / empty checks, start scan or head read
  //   PUSH_STEP read entry just below scan index, or insert at head
  //   PUSH_CMP  entry > value: shift it up one slot and keep scanning,
  //             otherwise insert value above it (equal values keep arrival order)
  //   POP_DATA  return head entry, advance head, drain on last entry
  // Any step that produces a result holds until the output register is free.
  spq_cmd_t  cmd;
  spq_stat_t st;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: single-port-write entry memory with registered read, head/tail
  // pointers, scan index, signed compare and the result register.
  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_value         (in_value),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_status       (out_status)
  );

  // A request is worked on alone: the cycle after acceptance the input is stalled.
  `SPQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "request accepted while busy")
  // Results are only produced when the output register can take them.
  `SPQ_ASSERT_NOW(a_emit_when_free, clk, rst_n, cmd.emit, st.out_free, "result overwrote pending result")
  // The head entry is only read when the queue holds something.
  `SPQ_ASSERT_NOW(a_pop_not_empty, clk, rst_n, cmd.rd_head, !st.empty, "pop read on empty queue")
  // A shift and an insert never hit the memory in the same cycle.
  `SPQ_ASSERT_NOW(a_one_write, clk, rst_n, cmd.shift, !cmd.insert && !cmd.emit, "two memory writes")

endmodule

// ----- hdl/spq_ctrl.sv -----
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_stat_t st,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!st.is_pop) begin
          if (!st.full) state_nxt = ST_PUSH_STEP;
          else if (st.out_free) state_nxt = ST_IDLE;
        end else begin
          if (!st.empty) state_nxt = ST_POP_DATA;
          else if (st.out_free) state_nxt = ST_IDLE;
        end
      end
      ST_PUSH_STEP: begin
        if (!st.at_head) state_nxt = ST_PUSH_CMP;
        else if (st.out_free) state_nxt = ST_IDLE;
      end
      ST_PUSH_CMP: begin
        if (st.rd_gt) state_nxt = ST_PUSH_STEP;
        else if (st.out_free) state_nxt = ST_IDLE;
      end
      ST_POP_DATA: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    cmd.emit_status = STAT_OK;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_EXEC: begin
        if (!st.is_pop) begin
          if (st.full) begin
            cmd.emit        = st.out_free;
            cmd.emit_status = STAT_FULL;
          end else begin
            cmd.init_idx = 1'b1;
          end
        end else begin
          if (st.empty) begin
            cmd.emit        = st.out_free;
            cmd.emit_status = STAT_EMPTY;
          end else begin
            cmd.rd_head = 1'b1;
          end
        end
      end
      ST_PUSH_STEP: begin
        if (st.at_head) begin
          cmd.insert = st.out_free;
          cmd.emit   = st.out_free;
        end else begin
          cmd.rd_prev = 1'b1;
        end
      end
      ST_PUSH_CMP: begin
        if (st.rd_gt) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.insert = st.out_free;
          cmd.emit   = st.out_free;
        end
      end
      ST_POP_DATA: begin
        cmd.emit     = st.out_free;
        cmd.emit_pop = st.out_free;
        cmd.pop_adv  = st.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- hdl/spq_dp.sv -----
module spq_dp #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_action,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value,
  input  spq_pkg::spq_cmd_t                 cmd,
  output spq_pkg::spq_stat_t                st,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [spq_pkg::DATA_W-1:0] out_popped_value,
  output logic [spq_pkg::STATUS_W-1:0]      out_status
);
  import spq_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int TAIL_W = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic                     act_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic [IDX_W-1:0]         head_r;
  logic [TAIL_W-1:0]        tail_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [STATUS_W-1:0]      out_status_r;

  logic [TAIL_W-1:0] head_ext;
  logic [TAIL_W-1:0] head_inc;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;

  assign head_ext = TAIL_W'(head_r);
  assign head_inc = head_ext + TAIL_W'(1);
  assign rd_en    = cmd.rd_prev | cmd.rd_head;
  assign rd_addr  = cmd.rd_head ? head_r : (idx_r - IDX_W'(1));

  assign st.is_pop   = act_r;
  assign st.full     = (tail_r >= TAIL_W'(CAPACITY));
  assign st.empty    = (tail_r == '0) || (head_ext >= tail_r);
  assign st.at_head  = (idx_r == head_r);
  assign st.rd_gt    = (rd_data_r > val_r);
  assign st.out_free = !out_valid_r || !out_stall;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      val_r <= in_value;
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem[idx_r] <= rd_data_r;
    end else if (cmd.insert) begin
      mem[idx_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_idx) begin
      idx_r <= tail_r[IDX_W-1:0];
    end else if (cmd.shift) begin
      idx_r <= idx_r - IDX_W'(1);
    end
  end

  // head / tail
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (cmd.init_idx && (tail_r == '0)) begin
        head_r <= '0;
      end
      if (cmd.insert) begin
        tail_r <= tail_r + TAIL_W'(1);
      end
      if (cmd.pop_adv) begin
        if (head_inc >= tail_r) begin
          head_r <= '0;
          tail_r <= '0;
        end else begin
          head_r <= head_r + IDX_W'(1);
        end
      end
      if (cmd.emit && (cmd.emit_status == STAT_EMPTY)) begin
        head_r <= '0;
        tail_r <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= cmd.emit_pop ? rd_data_r : '0;
      out_status_r <= cmd.emit_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;

endmodule
